/* rtl/text_terminal_character_grid_macros.svh */
// Assertion macros shared by the character grid RTL.
// Pulled in by text_terminal_character_grid.sv; depends on nothing else.
`ifndef TEXT_TERMINAL_CHARACTER_GRID_MACROS_SVH
`define TEXT_TERMINAL_CHARACTER_GRID_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTCG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ttcg_pkg.sv */
// Types, constants and address helpers for the text terminal character grid.
// Used by text_terminal_character_grid.sv; depends on nothing.
`default_nettype none

package ttcg_pkg;

   localparam int COLUMNS = 80;
   localparam int LINES   = 30;
   localparam int CELLS   = COLUMNS * LINES;

   localparam int ROW_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ADDR_W = $clog2(CELLS);

   // Fixed field widths of the channels
   localparam int ROW_FIELD_W  = 5;
   localparam int COL_FIELD_W  = 7;
   localparam int CHAR_W       = 8;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
   localparam logic [CHAR_W-1:0] GLYPH_CURSOR = 8'hDB;

   typedef struct packed {
      logic                   opcode;
      logic [CHAR_W-1:0]      char_code;
      logic [ROW_FIELD_W-1:0] read_row;
      logic [COL_FIELD_W-1:0] read_col;
   } ttcg_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      glyph;
      logic                   at_cursor;
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
      logic                   scrolled;
   } ttcg_rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_RDATA,
      ST_BSWR,
      ST_SCROLL,
      ST_DONE
   } ttcg_state_type;

   // Map a logical row to its physical row in the circular row store.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] row);
      logic [ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (ROW_W+1)'(LINES)) begin
         sum = sum - (ROW_W+1)'(LINES);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(prow) * ADDR_W'(COLUMNS);
      return base + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

/* rtl/ttcg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; instantiated by text_terminal_character_grid.sv.
`default_nettype none

module ttcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2400
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/text_terminal_character_grid.sv */
// Text terminal character grid: cursor control, put/read sequencer, cell RAM.
// Depends on ttcg_pkg, ttcg_ram and text_terminal_character_grid_macros.svh.
//
// Usage:
//   req_* carries one item: a put of char_code (opcode 0) or a read of the
//   cell at read_row/read_col (opcode 1). rsp_* returns exactly one item per
//   request: the glyph read (0xDB at the cursor), the cursor after the item
//   and a scroll flag. Both channels are valid/ready.
//   One item is processed at a time. After a read is accepted it passes the
//   execute, RAM read and result steps before rsp_valid rises; a plain put
//   passes execute and result, and a backspace that moves the cursor adds a
//   clearing write step between them. The next item is accepted once the
//   result step is left. A put that scrolls adds a step that clears the new
//   bottom row, one RAM write per cycle; rows are never copied, a top-row
//   pointer moves. After reset the block sweeps the whole cell RAM to zero,
//   all LINES*COLUMNS cells (2400), with req_ready low.
//   The result sits in an output register; a new request is accepted while
//   it waits, and that item then holds in its last step until rsp_ready
//   frees the register.
`default_nettype none
`include "text_terminal_character_grid_macros.svh"

module text_terminal_character_grid (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ttcg_pkg::ttcg_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ttcg_pkg::ttcg_rsp_type      rsp_data
);

   ttcg_pkg::ttcg_state_type state_ff, state_in;

   logic [ttcg_pkg::ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ttcg_pkg::COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ttcg_pkg::ROW_W-1:0]  top_ff, top_in;
   logic [ttcg_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ttcg_pkg::ADDR_W-1:0] clr_last_ff, clr_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   ttcg_pkg::ttcg_req_type      item_ff, item_in;
   ttcg_pkg::ttcg_rsp_type      rsp_data_ff, rsp_data_in;
   logic [ttcg_pkg::CHAR_W-1:0] glyph_ff, glyph_in;
   logic                        at_cur_ff, at_cur_in;
   logic                        in_grid_ff, in_grid_in;
   logic                        scrolled_ff, scrolled_in;

   logic                        ram_wr_en;
   logic [ttcg_pkg::ADDR_W-1:0] ram_wr_addr;
   logic [ttcg_pkg::CHAR_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [ttcg_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [ttcg_pkg::CHAR_W-1:0] ram_rd_data;

   logic [ttcg_pkg::ROW_W-1:0]  rd_row;
   logic [ttcg_pkg::COL_W-1:0]  rd_col;
   logic                        rd_in_grid;
   logic                        rd_hit;
   logic [ttcg_pkg::ADDR_W-1:0] cur_addr;
   logic [ttcg_pkg::ADDR_W-1:0] rd_addr;
   logic [ttcg_pkg::ADDR_W-1:0] scroll_base;
   logic                        last_row;
   logic                        last_col;
   logic                        do_scroll;

   ttcg_ram #(
      .WIDTH (ttcg_pkg::CHAR_W),
      .DEPTH (ttcg_pkg::CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Address and compare terms
   always_comb begin
      rd_row      = ttcg_pkg::ROW_W'(item_ff.read_row);
      rd_col      = ttcg_pkg::COL_W'(item_ff.read_col);
      rd_in_grid  = (32'(item_ff.read_row) < 32'(ttcg_pkg::LINES)) &&
                    (32'(item_ff.read_col) < 32'(ttcg_pkg::COLUMNS));
      rd_hit      = rd_in_grid && (rd_row == cur_row_ff) && (rd_col == cur_col_ff);
      cur_addr    = ttcg_pkg::cell_addr(ttcg_pkg::phys_row(top_ff, cur_row_ff), cur_col_ff);
      rd_addr     = ttcg_pkg::cell_addr(ttcg_pkg::phys_row(top_ff, rd_row), rd_col);
      scroll_base = ttcg_pkg::cell_addr(top_ff, '0);
      last_row    = (cur_row_ff == ttcg_pkg::ROW_W'(ttcg_pkg::LINES - 1));
      last_col    = (cur_col_ff == ttcg_pkg::COL_W'(ttcg_pkg::COLUMNS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttcg_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         clr_addr_ff  <= '0;
         clr_last_ff  <= ttcg_pkg::ADDR_W'(ttcg_pkg::CELLS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         clr_addr_ff  <= clr_addr_in;
         clr_last_ff  <= clr_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
      glyph_ff    <= glyph_in;
      at_cur_ff   <= at_cur_in;
      in_grid_ff  <= in_grid_in;
      scrolled_ff <= scrolled_in;
   end

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      clr_addr_in  = clr_addr_ff;
      clr_last_in  = clr_last_ff;
      rsp_valid_in = rsp_valid_ff;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      glyph_in     = glyph_ff;
      at_cur_in    = at_cur_ff;
      in_grid_in   = in_grid_ff;
      scrolled_in  = scrolled_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_addr;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_addr;
      req_ready    = 1'b0;
      do_scroll    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ttcg_pkg::ST_INIT, ttcg_pkg::ST_SCROLL: begin
            // Sweep zeros from clr_addr up to clr_last
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            if (clr_addr_ff == clr_last_ff) begin
               state_in = (state_ff == ttcg_pkg::ST_INIT) ? ttcg_pkg::ST_IDLE
                                                          : ttcg_pkg::ST_DONE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ttcg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = ttcg_pkg::ST_EXEC;
            end
         end
         ttcg_pkg::ST_EXEC: begin
            scrolled_in = 1'b0;
            if (item_ff.opcode == ttcg_pkg::OP_READ) begin
               at_cur_in  = rd_hit;
               in_grid_in = rd_in_grid;
               ram_rd_en  = rd_in_grid;
               state_in   = ttcg_pkg::ST_RDATA;
            end else begin
               glyph_in  = '0;
               at_cur_in = 1'b0;
               state_in  = ttcg_pkg::ST_DONE;
               case (item_ff.char_code)
                  ttcg_pkg::CH_CR: begin
                     cur_col_in = '0;
                  end
                  ttcg_pkg::CH_LF: begin
                     cur_col_in = '0;
                     if (last_row) begin
                        do_scroll = 1'b1;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                  end
                  ttcg_pkg::CH_BS: begin
                     // Step back unless at the home cell, then clear there
                     if ((cur_row_ff != '0) || (cur_col_ff != '0)) begin
                        if (cur_col_ff == '0) begin
                           cur_row_in = cur_row_ff - 1'b1;
                           cur_col_in = ttcg_pkg::COL_W'(ttcg_pkg::COLUMNS - 1);
                        end else begin
                           cur_col_in = cur_col_ff - 1'b1;
                        end
                        state_in = ttcg_pkg::ST_BSWR;
                     end
                  end
                  default: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = item_ff.char_code;
                     if (last_col) begin
                        cur_col_in = '0;
                        if (last_row) begin
                           do_scroll = 1'b1;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
               endcase
               if (do_scroll) begin
                  // Old top row becomes the new bottom row; clear it
                  scrolled_in = 1'b1;
                  top_in      = (top_ff == ttcg_pkg::ROW_W'(ttcg_pkg::LINES - 1)) ?
                                '0 : top_ff + 1'b1;
                  cur_row_in  = ttcg_pkg::ROW_W'(ttcg_pkg::LINES - 1);
                  cur_col_in  = '0;
                  clr_addr_in = scroll_base;
                  clr_last_in = scroll_base + ttcg_pkg::ADDR_W'(ttcg_pkg::COLUMNS - 1);
                  state_in    = ttcg_pkg::ST_SCROLL;
               end
            end
         end
         ttcg_pkg::ST_RDATA: begin
            if (at_cur_ff) begin
               glyph_in = ttcg_pkg::GLYPH_CURSOR;
            end else if (in_grid_ff) begin
               glyph_in = ram_rd_data;
            end else begin
               glyph_in = '0;
            end
            state_in = ttcg_pkg::ST_DONE;
         end
         ttcg_pkg::ST_BSWR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_addr;
            ram_wr_data = '0;
            state_in    = ttcg_pkg::ST_DONE;
         end
         ttcg_pkg::ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.glyph      = glyph_ff;
               rsp_data_in.at_cursor  = at_cur_ff;
               rsp_data_in.cursor_row = ttcg_pkg::ROW_FIELD_W'(cur_row_ff);
               rsp_data_in.cursor_col = ttcg_pkg::COL_FIELD_W'(cur_col_ff);
               rsp_data_in.scrolled   = scrolled_ff;
               state_in               = ttcg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttcg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TTCG_ASSERT_NOW(a_no_rw_overlap, clock, reset, ram_rd_en, !ram_wr_en, "RAM read and write in one cycle")
   `TTCG_ASSERT_NOW(a_cursor_range, clock, reset, 1'b1, (cur_row_ff < ttcg_pkg::LINES) && (cur_col_ff < ttcg_pkg::COLUMNS), "cursor outside grid")
   `TTCG_ASSERT_NOW(a_top_range, clock, reset, 1'b1, top_ff < ttcg_pkg::LINES, "top row pointer outside grid")
   `TTCG_ASSERT_NOW(a_sweep_bound, clock, reset, (state_ff == ttcg_pkg::ST_INIT) || (state_ff == ttcg_pkg::ST_SCROLL), clr_addr_ff <= clr_last_ff, "clear sweep ran past its end")
   `TTCG_ASSERT_NEXT(a_scroll_cursor, clock, reset, (state_ff == ttcg_pkg::ST_EXEC) && do_scroll, (cur_row_ff == ttcg_pkg::ROW_W'(ttcg_pkg::LINES - 1)) && (cur_col_ff == '0) && (state_ff == ttcg_pkg::ST_SCROLL), "scroll did not home cursor to bottom row")

endmodule

`default_nettype wire

/* tb/tb_text_terminal_character_grid.sv */
// Self-checking testbench for the text terminal character grid: puts and reads
// over valid/ready channels, checked against a cycle-free model of the grid.
// Depends on ttcg_pkg and the text_terminal_character_grid RTL.

module tb_text_terminal_character_grid;

   localparam int ITEM_TARGET    = 1500;
   localparam int SETTLE_CYCLES  = 120;
   localparam int DRAIN_LIMIT    = 200000;
   localparam int TIMEOUT_CYCLES = 1500000;
   localparam int REQ_W          = $bits(ttcg_pkg::ttcg_req_type);

   typedef enum int {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH
   } idle_phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   ttcg_pkg::ttcg_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   ttcg_pkg::ttcg_rsp_type rsp_data;

   text_terminal_character_grid u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Grid model: screen bytes and cursor, advanced as each item is accepted
   logic [ttcg_pkg::CHAR_W-1:0] grid_mem [ttcg_pkg::LINES][ttcg_pkg::COLUMNS];
   int unsigned                 cur_y;
   int unsigned                 cur_x;

   ttcg_pkg::ttcg_req_type pending_q[$];
   ttcg_pkg::ttcg_rsp_type glyph_q[$];
   idle_phase_type         idle_phase = PH_FREE;
   int unsigned            queued_cnt, accepted_cnt, result_cnt, fail_cnt;
   int unsigned            scroll_cnt, backspace_cnt, cursor_read_cnt, outside_read_cnt;

   function automatic void scroll_grid();
      for (int r = 0; r < ttcg_pkg::LINES - 1; r++) begin
         for (int c = 0; c < ttcg_pkg::COLUMNS; c++) begin
            grid_mem[r][c] = grid_mem[r+1][c];
         end
      end
      for (int c = 0; c < ttcg_pkg::COLUMNS; c++) begin
         grid_mem[ttcg_pkg::LINES-1][c] = '0;
      end
      cur_y = ttcg_pkg::LINES - 1;
      cur_x = 0;
      scroll_cnt++;
   endfunction

   function automatic ttcg_pkg::ttcg_rsp_type terminal_step(input ttcg_pkg::ttcg_req_type it);
      ttcg_pkg::ttcg_rsp_type r;
      r = '0;
      if (it.opcode == ttcg_pkg::OP_PUT) begin
         if (it.char_code == ttcg_pkg::CH_CR) begin
            cur_x = 0;
         end else if (it.char_code == ttcg_pkg::CH_LF) begin
            cur_x = 0;
            cur_y++;
            if (cur_y >= ttcg_pkg::LINES) begin
               scroll_grid();
               r.scrolled = 1'b1;
            end
         end else if (it.char_code == ttcg_pkg::CH_BS) begin
            backspace_cnt++;
            // stay put at the home cell, leaving it untouched
            if (cur_y != 0 || cur_x != 0) begin
               if (cur_x == 0) begin
                  cur_y--;
                  cur_x = ttcg_pkg::COLUMNS - 1;
               end else begin
                  cur_x--;
               end
               grid_mem[cur_y][cur_x] = '0;
            end
         end else begin
            grid_mem[cur_y][cur_x] = it.char_code;
            cur_x++;
            if (cur_x >= ttcg_pkg::COLUMNS) begin
               cur_x = 0;
               cur_y++;
               if (cur_y >= ttcg_pkg::LINES) begin
                  scroll_grid();
                  r.scrolled = 1'b1;
               end
            end
         end
      end else if (it.read_row < ttcg_pkg::LINES && it.read_col < ttcg_pkg::COLUMNS) begin
         if (it.read_row == cur_y && it.read_col == cur_x) begin
            r.glyph     = ttcg_pkg::GLYPH_CURSOR;
            r.at_cursor = 1'b1;
            cursor_read_cnt++;
         end else begin
            r.glyph = grid_mem[it.read_row][it.read_col];
         end
      end else begin
         outside_read_cnt++;
      end
      r.cursor_row = ttcg_pkg::ROW_FIELD_W'(cur_y);
      r.cursor_col = ttcg_pkg::COL_FIELD_W'(cur_x);
      return r;
   endfunction

   function automatic bit sender_pause();
      case (idle_phase)
         PH_SEND_IDLE: return $urandom_range(99) < 71;
         PH_BOTH:      return $urandom_range(99) < 10;
         default:      return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (idle_phase)
         PH_RECV_STALL: return $urandom_range(99) < 71;
         PH_BOTH:       return $urandom_range(99) < 10;
         default:       return 1'b0;
      endcase
   endfunction

   // Driver: predict each accepted item, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            glyph_q.push_back(terminal_step(req_data));
            accepted_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() > 0 && !sender_pause()) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_cnt++;
      end
   endtask

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      ttcg_pkg::ttcg_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_cnt++;
            if (glyph_q.size() == 0) begin
               $error("result item arrived with no prediction pending");
               fail_cnt++;
            end else begin
               want = glyph_q.pop_front();
               check_field("glyph", want.glyph, rsp_data.glyph);
               check_field("at_cursor", 8'(want.at_cursor), 8'(rsp_data.at_cursor));
               check_field("cursor_row", 8'(want.cursor_row), 8'(rsp_data.cursor_row));
               check_field("cursor_col", 8'(want.cursor_col), 8'(rsp_data.cursor_col));
               check_field("scrolled", 8'(want.scrolled), 8'(rsp_data.scrolled));
            end
         end
         rsp_ready <= !receiver_stall();
      end
   end

   task automatic push_put(input logic [7:0] ch);
      ttcg_pkg::ttcg_req_type it;
      it.opcode    = ttcg_pkg::OP_PUT;
      it.char_code = ch;
      it.read_row  = ttcg_pkg::ROW_FIELD_W'($urandom);
      it.read_col  = ttcg_pkg::COL_FIELD_W'($urandom);
      pending_q.push_back(it);
      queued_cnt++;
   endtask

   task automatic push_read(input int unsigned row, input int unsigned col);
      ttcg_pkg::ttcg_req_type it;
      it.opcode    = ttcg_pkg::OP_READ;
      it.char_code = ttcg_pkg::CHAR_W'($urandom);
      it.read_row  = ttcg_pkg::ROW_FIELD_W'(row);
      it.read_col  = ttcg_pkg::COL_FIELD_W'(col);
      pending_q.push_back(it);
      queued_cnt++;
   endtask

   task automatic wait_accepted();
      while (accepted_cnt != queued_cnt) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned    seq_no, len, kind;
      idle_phase_type next_phase;
      logic [7:0]     ch;
      for (int r = 0; r < ttcg_pkg::LINES; r++) begin
         for (int c = 0; c < ttcg_pkg::COLUMNS; c++) begin
            grid_mem[r][c] = '0;
         end
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: home cell, byte extremes, CR, LF, backspace wrap, outside reads
      push_read(0, 0);
      push_put(ttcg_pkg::CH_BS);
      push_read(0, 0);
      push_put(8'h00);
      push_put(8'hFF);
      push_read(0, 1);
      push_read(0, 0);
      push_read(0, 2);
      push_put(ttcg_pkg::CH_CR);
      push_read(0, 0);
      push_put(ttcg_pkg::CH_LF);
      push_put(ttcg_pkg::CH_BS);
      push_put(8'h41);
      push_read(0, 79);
      push_read(30, 0);
      push_read(0, 80);
      push_read(31, 127);
      push_read(29, 79);
      push_put(8'h80);
      push_read(1, 0);

      seq_no = 0;
      while (queued_cnt < ITEM_TARGET) begin
         wait_accepted();
         next_phase = idle_phase_type'((queued_cnt * 4) / ITEM_TARGET);
         if (next_phase != idle_phase) begin
            // hold off until every outstanding result is back
            while (glyph_q.size() != 0) @(posedge clock);
            idle_phase = next_phase;
         end
         kind = $urandom_range(99);
         if (seq_no == 0 || (kind >= 35 && kind < 50)) begin
            len = (seq_no == 0) ? 30 : $urandom_range(1, 32);
            repeat (len) push_put(ttcg_pkg::CH_LF);
         end else if (kind < 35) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 170)
                                           : $urandom_range(0, 20);
            repeat (len) begin
               ch = ($urandom_range(4) == 0) ? ttcg_pkg::CHAR_W'($urandom)
                                             : ttcg_pkg::CHAR_W'($urandom_range(32, 126));
               push_put(ch);
            end
            case ($urandom_range(2))
               0: begin
                  push_put(ttcg_pkg::CH_CR);
                  push_put(ttcg_pkg::CH_LF);
               end
               1: push_put(ttcg_pkg::CH_LF);
               default: ;
            endcase
         end else if (kind < 60) begin
            len = $urandom_range(1, 90);
            repeat (len) push_put(ttcg_pkg::CH_BS);
         end else if (kind < 85) begin
            push_read(cur_y, cur_x);
            push_read(cur_y, (cur_x == 0) ? 0 : cur_x - 1);
            push_read(cur_y, $urandom_range(ttcg_pkg::COLUMNS - 1));
            push_read((cur_y == 0) ? 0 : cur_y - 1, $urandom_range(ttcg_pkg::COLUMNS - 1));
            push_read($urandom_range(ttcg_pkg::LINES - 1),
                      $urandom_range(ttcg_pkg::COLUMNS - 1));
            if ($urandom_range(1)) begin
               push_read($urandom_range(ttcg_pkg::LINES, 31), $urandom_range(127));
            end else begin
               push_read($urandom_range(31), $urandom_range(ttcg_pkg::COLUMNS, 127));
            end
         end else begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               pending_q.push_back(ttcg_pkg::ttcg_req_type'(REQ_W'($urandom)));
               queued_cnt++;
            end
         end
         seq_no++;
      end

      wait_accepted();
      for (int k = 0; k < DRAIN_LIMIT && glyph_q.size() != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (glyph_q.size() != 0) begin
         $error("%0d predicted result items never arrived", glyph_q.size());
         fail_cnt++;
      end

      $display("covered %0d items and %0d results over four idling phases",
               accepted_cnt, result_cnt);
      $display("scrolls %0d, backspaces %0d, cursor reads %0d, off-grid reads %0d",
               scroll_cnt, backspace_cnt, cursor_read_cnt, outside_read_cnt);
      if (fail_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("status: fail");
      $finish;
   end

endmodule
